@@ sv/chc_pkg.sv @@
// Shared types, status codes and helpers for the cartridge header check.
package chc_pkg;

  typedef enum logic [2:0] {
    HS_OK      = 3'd0,
    HS_SHORT   = 3'd1,
    HS_MAGIC   = 3'd2,
    HS_ARCHAIC = 3'd3,
    HS_SIZE    = 3'd4,
    HS_TRUNC   = 3'd5,
    HS_TRAIL   = 3'd6
  } chc_hdr_status_e;

  typedef enum logic [3:0] {
    SS_OK          = 4'd0,
    SS_CONSOLE     = 4'd1,
    SS_REGION      = 4'd2,
    SS_EXPANSION   = 4'd3,
    SS_TRAINER     = 4'd4,
    SS_FOUR_SCREEN = 4'd5,
    SS_MAPPER      = 4'd6,
    SS_SUBMAPPER   = 4'd7,
    SS_PRG         = 4'd8,
    SS_CHR         = 4'd9,
    SS_RAM         = 4'd10,
    SS_BATTERY     = 4'd11
  } chc_sup_status_e;

  localparam logic [31:0] MagicWord   = 32'h1a53454e;
  localparam logic [39:0] WriterSig   = 40'h312e32494e;
  localparam logic [4:0]  HdrBytes    = 5'd16;
  localparam logic [39:0] MinFileSize = 40'd16;
  localparam logic [21:0] RamUnit     = 22'd64;
  localparam logic [21:0] RamBank     = 22'd8192;

  typedef struct packed {
    logic [63:0] header_low;
    logic [63:0] header_high;
    logic [4:0]  header_count;
    logic [39:0] file_size;
  } chc_in_t;

  typedef struct packed {
    logic [2:0]  header_status;
    logic [3:0]  support_status;
    logic [11:0] mapper_number;
    logic [3:0]  submapper_number;
    logic [4:0]  header_flags;
    logic [1:0]  console_type;
    logic [1:0]  timing_region;
    logic [25:0] program_rom_bytes;
    logic [24:0] character_rom_bytes;
    logic [9:0]  program_offset;
    logic [26:0] expected_length;
    logic [21:0] program_ram_bytes;
  } chc_out_t;

  typedef struct packed {
    logic [2:0]  err;
    logic [11:0] map_no;
    logic [3:0]  sub_no;
    logic [4:0]  flags;
    logic [1:0]  cons;
    logic [1:0]  region;
    logic [5:0]  expn;
    logic [1:0]  misc;
    logic [25:0] prog;
    logic [24:0] chrb;
    logic [21:0] wram;
    logic [21:0] wnv;
    logic [21:0] vram;
    logic [21:0] vnv;
    logic [9:0]  poff;
    logic [39:0] fsz;
  } chc_dec_t;

  typedef struct packed {
    logic [2:0]  hs;
    logic [3:0]  early;
    logic        prg_bad;
    logic        chr_bad;
    logic [3:0]  tail;
    logic [11:0] map_no;
    logic [3:0]  sub_no;
    logic [4:0]  flags;
    logic [1:0]  cons;
    logic [1:0]  region;
    logic [25:0] prog;
    logic [24:0] chrb;
    logic [9:0]  poff;
    logic [26:0] total;
    logic [21:0] wram;
  } chc_chk_t;

  function automatic logic [21:0] shift_size(input logic [3:0] s);
    return (s == 4'd0) ? 22'd0 : (RamUnit << s);
  endfunction

  function automatic logic is_pow2(input logic [25:0] v);
    return (v != 26'd0) && ((v & (v - 26'd1)) == 26'd0);
  endfunction

endpackage

@@ sv/chc_if.sv @@
// Valid/ready channel interfaces for header beats and result beats.
interface chc_in_if;
  import chc_pkg::*;
  logic    valid;
  logic    ready;
  chc_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface chc_out_if;
  import chc_pkg::*;
  logic     valid;
  logic     ready;
  chc_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ sv/cartridge_header_check_core.sv @@
// Cartridge header check: three-stage pipeline that decodes and checks one header per beat.
// The block takes one header beat every cycle while no result is held and returns one result
// beat for each: stage one decodes fields and sizes and finds the early header
// errors, stage two adds up the expected length, compares it with the file size and evaluates
// the board profile rules, and stage three picks the support status, clears the fields of a
// failed header and holds the result. Each stage carries its own valid bit and advances when
// the stage after it is empty or moving, so a held result stalls the pipe without loss.
module cartridge_header_check_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  chc_in_if.sink    in_i,
  chc_out_if.source out_o
);
  import chc_pkg::*;

  logic       s1_valid_q, s2_valid_q, out_valid_q;
  logic       s1_ready, s2_ready, s3_ready;
  chc_dec_t   s1_d, s1_q;
  chc_chk_t   s2_d, s2_q;
  chc_out_t   out_d, out_q;
  logic [7:0] hb [16];
  logic       v2, writer, rsvd_nz;

  assign s3_ready   = !out_valid_q || out_o.ready;
  assign s2_ready   = !s2_valid_q || s3_ready;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_i.ready = s1_ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      hb[i]     = in_i.data.header_low[8*i +: 8];
      hb[i + 8] = in_i.data.header_high[8*i +: 8];
    end
  end

  assign v2      = (hb[7][3:2] == 2'b10);
  assign writer  = (in_i.data.header_high[63:24] == WriterSig);
  assign rsvd_nz = |in_i.data.header_high[63:32];

  // Stage one: field decode and early header errors
  always_comb begin
    s1_d        = '0;
    s1_d.fsz    = in_i.data.file_size;
    s1_d.flags  = {v2, hb[6][3:0]};
    s1_d.map_no = {(v2 ? hb[8][3:0] : 4'h0), hb[7][7:4], hb[6][7:4]};
    s1_d.cons   = hb[7][1:0];
    s1_d.poff   = hb[6][2] ? 10'd528 : 10'd16;
    if (v2) begin
      s1_d.sub_no = hb[8][7:4];
      s1_d.region = hb[12][1:0];
      s1_d.expn   = hb[15][5:0];
      s1_d.misc   = hb[14][1:0];
      s1_d.prog   = {hb[9][3:0], hb[4], 14'd0};
      s1_d.chrb   = {hb[9][7:4], hb[5], 13'd0};
      s1_d.wram   = shift_size(hb[10][3:0]);
      s1_d.wnv    = shift_size(hb[10][7:4]);
      s1_d.vram   = shift_size(hb[11][3:0]);
      s1_d.vnv    = shift_size(hb[11][7:4]);
    end else begin
      if (hb[10][1:0] == 2'd0) begin
        s1_d.region = {1'b0, hb[9][0]};
      end else if (hb[10][1:0] == 2'd2) begin
        s1_d.region = 2'd1;
      end else begin
        s1_d.region = 2'd2;
      end
      s1_d.prog = {4'd0, hb[4], 14'd0};
      s1_d.chrb = {4'd0, hb[5], 13'd0};
      s1_d.vram = (hb[5] == 8'd0) ? RamBank : 22'd0;
      if (hb[8] == 8'd0 && (s1_d.map_no == 12'd1 || s1_d.map_no == 12'd4)) begin
        s1_d.wram = RamBank;
      end else begin
        s1_d.wram = {1'b0, hb[8], 13'd0};
      end
    end
    if (in_i.data.header_count < HdrBytes || in_i.data.file_size < MinFileSize) begin
      s1_d.err = HS_SHORT;
    end else if (in_i.data.header_low[31:0] != MagicWord) begin
      s1_d.err = HS_MAGIC;
    end else if (v2) begin
      s1_d.err = (hb[9][3:0] == 4'hf || hb[9][7:4] == 4'hf) ? HS_SIZE : HS_OK;
    end else if (hb[7][3:2] != 2'b00 || (!writer && rsvd_nz)) begin
      s1_d.err = HS_ARCHAIC;
    end else begin
      s1_d.err = HS_OK;
    end
  end

  // Stage two: length check and board profile rules
  logic [25:0] p;
  logic [24:0] c;
  logic [11:0] m;
  logic [22:0] ram_sum;
  logic        simple, p_std, c_8k_128k;

  always_comb begin
    p         = s1_q.prog;
    c         = s1_q.chrb;
    m         = s1_q.map_no;
    ram_sum   = {1'b0, s1_q.wram} + {1'b0, s1_q.wnv};
    simple    = m inside {12'd2, 12'd3, 12'd7};
    p_std     = (p >= 26'd32768) && (p <= 26'd262144) && is_pow2(p);
    c_8k_128k = (c >= 25'd8192) && (c <= 25'd131072) && is_pow2({1'b0, c});

    s2_d        = '0;
    s2_d.map_no = s1_q.map_no;
    s2_d.sub_no = s1_q.sub_no;
    s2_d.flags  = s1_q.flags;
    s2_d.cons   = s1_q.cons;
    s2_d.region = s1_q.region;
    s2_d.prog   = s1_q.prog;
    s2_d.chrb   = s1_q.chrb;
    s2_d.poff   = s1_q.poff;
    s2_d.wram   = s1_q.wram;
    s2_d.total  = {17'd0, s1_q.poff} + {1'b0, s1_q.prog} + {2'd0, s1_q.chrb};

    if (s1_q.err != HS_OK) begin
      s2_d.hs = s1_q.err;
    end else if (s1_q.fsz < {13'd0, s2_d.total}) begin
      s2_d.hs = HS_TRUNC;
    end else if (s1_q.fsz > {13'd0, s2_d.total}) begin
      s2_d.hs = HS_TRAIL;
    end else begin
      s2_d.hs = HS_OK;
    end

    if (s1_q.cons != 2'd0) begin
      s2_d.early = SS_CONSOLE;
    end else if (s1_q.region != 2'd0) begin
      s2_d.early = SS_REGION;
    end else if (s1_q.misc != 2'd0 || s1_q.expn > 6'd1) begin
      s2_d.early = SS_EXPANSION;
    end else if (s1_q.flags[2]) begin
      s2_d.early = SS_TRAINER;
    end else if (s1_q.flags[3]) begin
      s2_d.early = SS_FOUR_SCREEN;
    end else if (!(m inside {12'd0, 12'd1, 12'd2, 12'd3, 12'd4, 12'd7, 12'd11})) begin
      s2_d.early = SS_MAPPER;
    end else if (s1_q.sub_no != 4'd0 && !(simple && s1_q.sub_no <= 4'd2)) begin
      s2_d.early = SS_SUBMAPPER;
    end else begin
      s2_d.early = SS_OK;
    end

    if (s1_q.flags[1] || s1_q.wnv != 22'd0 || s1_q.vnv != 22'd0) begin
      s2_d.tail = SS_BATTERY;
    end else if (s1_q.wram != 22'd0 || (c != 25'd0 && s1_q.vram != 22'd0)) begin
      s2_d.tail = SS_RAM;
    end else begin
      s2_d.tail = SS_OK;
    end

    case (m)
      12'd0, 12'd3: begin
        s2_d.prg_bad = (p != 26'd16384) && (p != 26'd32768);
        if (m == 12'd0) begin
          s2_d.chr_bad = (c != 25'd8192) && !(c == 25'd0 && s1_q.vram == RamBank);
        end else begin
          s2_d.chr_bad = (c < 25'd8192) || (c > 25'd32768) || !is_pow2({1'b0, c});
        end
      end
      12'd1, 12'd4: begin
        s2_d.prg_bad = (p < ((m == 12'd4) ? 26'd32768 : 26'd16384)) ||
                       (p > 26'd262144) || !is_pow2(p);
        if (c != 25'd0) begin
          s2_d.chr_bad = !c_8k_128k;
        end else begin
          s2_d.chr_bad = (s1_q.vram != RamBank) || (s1_q.vnv != 22'd0);
        end
        s2_d.tail = ((c != 25'd0 && (s1_q.vram != 22'd0 || s1_q.vnv != 22'd0)) ||
                     s1_q.wram > RamBank || s1_q.wnv > RamBank ||
                     ram_sum > {1'b0, RamBank} ||
                     (ram_sum != 23'd0 && ram_sum != {1'b0, RamBank})) ? SS_RAM : SS_OK;
      end
      12'd2, 12'd7: begin
        s2_d.prg_bad = !p_std;
        s2_d.chr_bad = (c != 25'd0) || (s1_q.vram != RamBank) || (s1_q.vnv != 22'd0);
      end
      default: begin
        s2_d.prg_bad = (p != 26'd32768) && (p != 26'd65536) && (p != 26'd131072);
        s2_d.chr_bad = !c_8k_128k;
      end
    endcase
  end

  // Stage three: support status priority and error masking
  always_comb begin
    out_d = '0;
    out_d.header_status = s2_q.hs;
    if (s2_q.hs == HS_OK) begin
      if (s2_q.early != SS_OK) begin
        out_d.support_status = s2_q.early;
      end else if (s2_q.prg_bad) begin
        out_d.support_status = SS_PRG;
      end else if (s2_q.chr_bad) begin
        out_d.support_status = SS_CHR;
      end else begin
        out_d.support_status = s2_q.tail;
      end
      out_d.mapper_number       = s2_q.map_no;
      out_d.submapper_number    = s2_q.sub_no;
      out_d.header_flags        = s2_q.flags;
      out_d.console_type        = s2_q.cons;
      out_d.timing_region       = s2_q.region;
      out_d.program_rom_bytes   = s2_q.prog;
      out_d.character_rom_bytes = s2_q.chrb;
      out_d.program_offset      = s2_q.poff;
      out_d.expected_length     = s2_q.total;
      out_d.program_ram_bytes   = s2_q.wram;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
      if (s3_ready) begin
        out_valid_q <= s2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && s1_ready) begin
      s1_q <= s1_d;
    end
    if (s1_valid_q && s2_ready) begin
      s2_q <= s2_d;
    end
    if (s2_valid_q && s3_ready) begin
      out_q <= out_d;
    end
  end

`ifndef ASSERT_OFF
  a_error_clears_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.header_status != HS_OK |->
      out_q.support_status == SS_OK && out_q.mapper_number == 12'd0 &&
      out_q.expected_length == 27'd0)
    else $error("failed header left nonzero result fields");

  a_length_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.header_status == HS_OK |->
      out_q.expected_length == {17'd0, out_q.program_offset} +
        {1'b0, out_q.program_rom_bytes} + {2'd0, out_q.character_rom_bytes})
    else $error("expected length does not match offset and ROM sizes");

  a_offset_trainer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.header_status == HS_OK |->
      out_q.program_offset == (out_q.header_flags[2] ? 10'd528 : 10'd16))
    else $error("program offset disagrees with trainer flag");

  a_stage1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s2_ready |=> s1_valid_q && $stable(s1_q))
    else $error("stalled stage one beat lost or changed");

  a_stage2_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q && !s3_ready |=> s2_valid_q && $stable(s2_q))
    else $error("stalled stage two beat lost or changed");
`endif

endmodule

@@ dv/cartridge_header_check_core_checker.sv @@
// Checker for the cartridge header check: predicts each result beat and compares it.
`timescale 1ns / 1ps

module cartridge_header_check_core_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              hdr_valid_i,
  input  logic              hdr_ready_i,
  input  chc_pkg::chc_in_t  hdr_data_i,
  input  logic              res_valid_i,
  input  logic              res_ready_i,
  input  chc_pkg::chc_out_t res_data_i,
  output int                mismatch_count_o,
  output int                outstanding_o
);
  import chc_pkg::*;

  chc_out_t predicted_results[$];
  chc_out_t want;

  function automatic int unsigned ram_from_shift(input logic [3:0] s);
    return (s == 4'd0) ? 0 : (64 << s);
  endfunction

  function automatic bit is_power_of_two(input int unsigned v);
    return (v != 0) && ((v & (v - 1)) == 0);
  endfunction

  function automatic chc_out_t predict_header_result(input chc_in_t hdr);
    logic [7:0] b [16];
    int unsigned i, map_no, sub_no, cons, region, expn, misc;
    int unsigned prog, chrb, wram, wnv, vram, vnv, poff, total, bank_sum;
    bit vert, batt, trn, four, v2, writer, simple, prg_ok, chr_ok, chr_ram_bad;
    chc_sup_status_e sup;
    chc_out_t res;
    res = '0;
    sub_no = 0;
    region = 0;
    expn = 0;
    misc = 0;
    wram = 0;
    wnv = 0;
    vram = 0;
    vnv = 0;
    for (i = 0; i < 8; i++) begin
      b[i] = hdr.header_low[8*i +: 8];
      b[i + 8] = hdr.header_high[8*i +: 8];
    end
    if (hdr.header_count < 5'd16 || hdr.file_size < 40'd16) begin
      res.header_status = HS_SHORT;
      return res;
    end
    if ({b[3], b[2], b[1], b[0]} != 32'h1a53454e) begin
      res.header_status = HS_MAGIC;
      return res;
    end
    v2 = (b[7][3:2] == 2'b10);
    map_no = 32'({b[7][7:4], b[6][7:4]});
    vert = b[6][0];
    batt = b[6][1];
    trn = b[6][2];
    four = b[6][3];
    cons = 32'(b[7][1:0]);
    if (v2) begin
      map_no = 32'({b[8][3:0], b[7][7:4], b[6][7:4]});
      sub_no = 32'(b[8][7:4]);
      region = 32'(b[12][1:0]);
      expn = 32'(b[15][5:0]);
      misc = 32'(b[14][1:0]);
      if (b[9][3:0] == 4'hf || b[9][7:4] == 4'hf) begin
        res.header_status = HS_SIZE;
        return res;
      end
      prog = {b[9][3:0], b[4]} * 16384;
      chrb = {b[9][7:4], b[5]} * 8192;
      wram = ram_from_shift(b[10][3:0]);
      wnv = ram_from_shift(b[10][7:4]);
      vram = ram_from_shift(b[11][3:0]);
      vnv = ram_from_shift(b[11][7:4]);
    end else begin
      writer = (hdr.header_high[63:24] == 40'h312e32494e);
      if (b[7][3:2] != 2'b00 || (!writer && hdr.header_high[63:32] != 32'd0)) begin
        res.header_status = HS_ARCHAIC;
        return res;
      end
      region = 32'(b[9][0]);
      if (b[10][1:0] != 2'b00) region = (b[10][1:0] == 2'b10) ? 1 : 2;
      prog = b[4] * 16384;
      chrb = b[5] * 8192;
      vram = (chrb != 0) ? 0 : 8192;
      wram = b[8] * 8192;
      if ((map_no == 1 || map_no == 4) && wram == 0) wram = 8192;
    end
    poff = trn ? 528 : 16;
    total = poff + prog + chrb;
    if (hdr.file_size < total) begin
      res.header_status = HS_TRUNC;
      return res;
    end
    if (hdr.file_size > total) begin
      res.header_status = HS_TRAIL;
      return res;
    end

    res.header_status = HS_OK;
    res.mapper_number = map_no[11:0];
    res.submapper_number = sub_no[3:0];
    res.header_flags = {v2, four, trn, batt, vert};
    res.console_type = cons[1:0];
    res.timing_region = region[1:0];
    res.program_rom_bytes = prog[25:0];
    res.character_rom_bytes = chrb[24:0];
    res.program_offset = poff[9:0];
    res.expected_length = total[26:0];
    res.program_ram_bytes = wram[21:0];

    prg_ok = 1'b0;
    chr_ok = 1'b0;
    chr_ram_bad = 1'b0;
    bank_sum = wram + wnv;
    case (map_no)
      0: begin
        prg_ok = (prog == 16384 || prog == 32768);
        chr_ok = (chrb == 8192) || (chrb == 0 && vram == 8192);
      end
      1, 4: begin
        prg_ok = prog >= ((map_no == 4) ? 32768 : 16384) && prog <= 262144 &&
                 is_power_of_two(prog);
        if (chrb != 0) begin
          chr_ok = chrb >= 8192 && chrb <= 131072 && is_power_of_two(chrb);
          chr_ram_bad = (vram != 0 || vnv != 0);
        end else begin
          chr_ok = (vram == 8192 && vnv == 0);
        end
      end
      2, 7: begin
        prg_ok = prog >= 32768 && prog <= 262144 && is_power_of_two(prog);
        chr_ok = (chrb == 0 && vram == 8192 && vnv == 0);
      end
      3: begin
        prg_ok = (prog == 16384 || prog == 32768);
        chr_ok = chrb >= 8192 && chrb <= 32768 && is_power_of_two(chrb);
      end
      default: begin
        prg_ok = (prog == 32768 || prog == 65536 || prog == 131072);
        chr_ok = chrb >= 8192 && chrb <= 131072 && is_power_of_two(chrb);
      end
    endcase
    simple = (map_no == 2 || map_no == 3 || map_no == 7);

    if (cons != 0) sup = SS_CONSOLE;
    else if (region != 0) sup = SS_REGION;
    else if (misc != 0 || expn > 1) sup = SS_EXPANSION;
    else if (trn) sup = SS_TRAINER;
    else if (four) sup = SS_FOUR_SCREEN;
    else if (map_no != 0 && map_no != 1 && map_no != 2 && map_no != 3 && map_no != 4 &&
             map_no != 7 && map_no != 11) sup = SS_MAPPER;
    else if (sub_no != 0 && !(simple && sub_no <= 2)) sup = SS_SUBMAPPER;
    else if (!prg_ok) sup = SS_PRG;
    else if (!chr_ok) sup = SS_CHR;
    else if (map_no == 1 || map_no == 4)
      sup = (chr_ram_bad || wram > 8192 || wnv > 8192 || bank_sum > 8192 ||
             (bank_sum != 0 && bank_sum != 8192)) ? SS_RAM : SS_OK;
    else if (batt || wnv != 0 || vnv != 0) sup = SS_BATTERY;
    else if (wram != 0 || (chrb != 0 && vram != 0)) sup = SS_RAM;
    else sup = SS_OK;
    res.support_status = sup;
    return res;
  endfunction

  task automatic check_field(input string name, input logic [63:0] exp_val,
                             input logic [63:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val, act_val);
      mismatch_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      predicted_results.delete();
      mismatch_count_o = 0;
    end else begin
      if (res_valid_i && res_ready_i) begin
        if (predicted_results.size() == 0) begin
          $display("%0t: result beat with none expected, expected nothing, actual %h",
                   $time, res_data_i);
          mismatch_count_o++;
        end else begin
          want = predicted_results.pop_front();
          check_field("header_status", 64'(want.header_status),
                      64'(res_data_i.header_status));
          check_field("support_status", 64'(want.support_status),
                      64'(res_data_i.support_status));
          check_field("mapper_number", 64'(want.mapper_number),
                      64'(res_data_i.mapper_number));
          check_field("submapper_number", 64'(want.submapper_number),
                      64'(res_data_i.submapper_number));
          check_field("header_flags", 64'(want.header_flags),
                      64'(res_data_i.header_flags));
          check_field("console_type", 64'(want.console_type),
                      64'(res_data_i.console_type));
          check_field("timing_region", 64'(want.timing_region),
                      64'(res_data_i.timing_region));
          check_field("program_rom_bytes", 64'(want.program_rom_bytes),
                      64'(res_data_i.program_rom_bytes));
          check_field("character_rom_bytes", 64'(want.character_rom_bytes),
                      64'(res_data_i.character_rom_bytes));
          check_field("program_offset", 64'(want.program_offset),
                      64'(res_data_i.program_offset));
          check_field("expected_length", 64'(want.expected_length),
                      64'(res_data_i.expected_length));
          check_field("program_ram_bytes", 64'(want.program_ram_bytes),
                      64'(res_data_i.program_ram_bytes));
        end
      end
      if (hdr_valid_i && hdr_ready_i)
        predicted_results.push_back(predict_header_result(hdr_data_i));
    end
    outstanding_o = predicted_results.size();
  end

endmodule

@@ dv/cartridge_header_check_core_tb.sv @@
// Testbench top for the cartridge header check: clock, reset, header stimulus and verdict.
`timescale 1ns / 1ps

module cartridge_header_check_core_tb;
  import chc_pkg::*;

  localparam int StallLimit    = 2000;
  localparam int HoldOffCycles = 300;
  localparam int RandomBeats   = 900;
  localparam logic [63:0] PlainLow = 64'h0000_0101_1a53_454e;
  localparam logic [63:0] V2Low    = 64'h0820_0002_1a53_454e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int phase = 0;
  int beat_idx = 0;
  int idle_cycles = 0;
  int mismatches;
  int outstanding;
  bit held_off = 1'b0;
  chc_in_t header_beats[$];

  chc_in_if hdr_ch ();
  chc_out_if res_ch ();

  cartridge_header_check_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (hdr_ch),
    .out_o  (res_ch)
  );

  cartridge_header_check_core_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .hdr_valid_i      (hdr_ch.valid),
    .hdr_ready_i      (hdr_ch.ready),
    .hdr_data_i       (hdr_ch.data),
    .res_valid_i      (res_ch.valid),
    .res_ready_i      (res_ch.ready),
    .res_data_i       (res_ch.data),
    .mismatch_count_o (mismatches),
    .outstanding_o    (outstanding)
  );

  always #6 clk_i = ~clk_i;

  function automatic chc_in_t make_beat(input logic [63:0] lo, input logic [63:0] hi,
                                        input logic [4:0] cnt, input logic [39:0] fsz);
    chc_in_t h;
    h.header_low = lo;
    h.header_high = hi;
    h.header_count = cnt;
    h.file_size = fsz;
    return h;
  endfunction

  function automatic chc_in_t random_header();
    logic [7:0] b [16];
    logic [11:0] mapper, prg_units, chr_units;
    logic [3:0] flags;
    logic v2;
    bit noise;
    int unsigned i, total;
    chc_in_t h;
    for (i = 0; i < 16; i++) b[i] = 8'($urandom);
    noise = ($urandom_range(0, 9) == 0);
    if (!noise || $urandom_range(0, 1) == 1) {b[3], b[2], b[1], b[0]} = 32'h1a53454e;
    total = 0;
    if (!noise) begin
      case ($urandom_range(0, 7))
        0: mapper = 12'd0;
        1: mapper = 12'd1;
        2: mapper = 12'd2;
        3: mapper = 12'd3;
        4: mapper = 12'd4;
        5: mapper = 12'd7;
        6: mapper = 12'd11;
        default: mapper = 12'($urandom);
      endcase
      v2 = 1'($urandom);
      prg_units = ($urandom_range(0, 9) == 0) ? 12'($urandom_range(0, 3839)) :
                  12'(1 << $urandom_range(0, 5));
      chr_units = ($urandom_range(0, 3) == 0) ? 12'd0 :
                  ($urandom_range(0, 9) == 0) ? 12'($urandom_range(0, 3839)) :
                  12'(1 << $urandom_range(0, 4));
      if (!v2) begin
        prg_units[11:8] = 4'd0;
        chr_units[11:8] = 4'd0;
      end
      flags = ($urandom_range(0, 3) == 0) ? 4'($urandom) : {3'b000, 1'($urandom)};
      b[4] = prg_units[7:0];
      b[5] = chr_units[7:0];
      b[6] = {mapper[3:0], flags};
      b[7] = {mapper[7:4], v2, 1'b0, ($urandom_range(0, 9) == 0) ? 2'($urandom) : 2'b00};
      if ($urandom_range(0, 19) == 0) b[7][3:2] = 2'($urandom);
      if (v2) begin
        b[8] = {($urandom_range(0, 3) == 0) ? 4'($urandom) :
                ($urandom_range(0, 2) == 0) ? 4'($urandom_range(1, 2)) : 4'd0,
                mapper[11:8]};
        b[9] = {chr_units[11:8], prg_units[11:8]};
        if ($urandom_range(0, 24) == 0) b[9] = b[9] | (($urandom_range(0, 1) == 1) ?
                                                       8'h0f : 8'hf0);
        case ($urandom_range(0, 3))
          0: b[10] = 8'h00;
          1: b[10] = 8'h07;
          2: b[10] = 8'h70;
          default: ;
        endcase
        if ($urandom_range(0, 7) != 0) b[11] = (chr_units == 12'd0) ? 8'h07 : 8'h00;
        if ($urandom_range(0, 7) != 0) b[12] = 8'h00;
        if ($urandom_range(0, 7) != 0) b[14] = 8'h00;
        if ($urandom_range(0, 7) != 0) b[15] = 8'($urandom_range(0, 1));
      end else begin
        if ($urandom_range(0, 2) != 0) b[8] = 8'($urandom_range(0, 1));
        if ($urandom_range(0, 7) != 0) b[9] = 8'h00;
        if ($urandom_range(0, 7) != 0) b[10] = 8'h00;
        case ($urandom_range(0, 9))
          0: {b[15], b[14], b[13], b[12], b[11]} = 40'h312e32494e;
          1: ;
          default: {b[15], b[14], b[13], b[12]} = 32'd0;
        endcase
      end
      total = (flags[2] ? 528 : 16) + prg_units * 16384 + chr_units * 8192;
    end
    for (i = 0; i < 8; i++) begin
      h.header_low[8*i +: 8] = b[i];
      h.header_high[8*i +: 8] = b[i + 8];
    end
    h.header_count = 5'd16;
    h.file_size = 40'(total);
    if (noise || $urandom_range(0, 9) == 0) h.header_count = 5'($urandom_range(0, 31));
    if (noise) begin
      h.file_size = {8'($urandom), 32'($urandom)};
    end else begin
      case ($urandom_range(0, 11))
        0: h.file_size = 40'(total - 1);
        1: h.file_size = 40'(total + 1);
        2: h.file_size = {8'($urandom), 32'($urandom)};
        default: ;
      endcase
    end
    return h;
  endfunction

  // stall watchdog
  always @(posedge clk_i) begin
    if (rst_ni && !(hdr_ch.valid && hdr_ch.ready) && !(res_ch.valid && res_ch.ready))
      idle_cycles <= idle_cycles + 1;
    else
      idle_cycles <= 0;
    if (idle_cycles >= StallLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // result sink: random backpressure plus one long hold-off
  initial begin
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (phase >= 2 && !held_off) begin
        held_off = 1'b1;
        res_ch.ready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
      end
      res_ch.ready <= ($urandom_range(0, 99) >= (phase == 0 ? 57 : (phase == 1 ? 32 : 0)));
    end
  end

  initial begin
    hdr_ch.valid = 1'b0;
    hdr_ch.data = '0;
    res_ch.ready = 1'b0;

    header_beats.push_back(make_beat(PlainLow, 64'd0, 5'd16, 40'd24592));
    header_beats.push_back(make_beat(PlainLow, 64'd0, 5'd15, 40'd24592));
    header_beats.push_back(make_beat(PlainLow, 64'd0, 5'd31, 40'd24592));
    header_beats.push_back(make_beat(PlainLow, 64'd0, 5'd16, 40'd15));
    header_beats.push_back(make_beat(64'h0000_0101_1a53_454f, 64'd0, 5'd16, 40'd24592));
    header_beats.push_back(make_beat(64'h0400_0101_1a53_454e, 64'd0, 5'd16, 40'd24592));
    header_beats.push_back(make_beat(PlainLow, 64'h0000_0001_0000_0000, 5'd16, 40'd24592));
    header_beats.push_back(make_beat(PlainLow, 64'h312e_3249_4e00_0000, 5'd16, 40'd24592));
    header_beats.push_back(make_beat(PlainLow, 64'h0000_0000_0002_0000, 5'd16, 40'd24592));
    header_beats.push_back(make_beat(PlainLow, 64'h0000_0000_0003_0100, 5'd16, 40'd24592));
    header_beats.push_back(make_beat(64'h0010_0002_1a53_454e, 64'd0, 5'd16, 40'd32784));
    header_beats.push_back(make_beat(64'h0046_1008_1a53_454e, 64'd0, 5'd16, 40'd262672));
    header_beats.push_back(make_beat(V2Low, 64'h0000_0000_0700_0000, 5'd16, 40'd32784));
    header_beats.push_back(make_beat(V2Low, 64'h0000_0000_0700_0f00, 5'd16, 40'd32784));
    header_beats.push_back(make_beat(V2Low, 64'h0000_0000_0700_f000, 5'd16, 40'd32784));
    header_beats.push_back(make_beat(64'h0800_ffff_1a53_454e, 64'h0000_0000_0000_ee00,
                                     5'd16, 40'd94347280));
    header_beats.push_back(make_beat(64'hf9f0_0101_1a53_454e, 64'hffff_ffff_ffff_00ff,
                                     5'd16, 40'd24592));
    header_beats.push_back(make_beat(PlainLow, 64'd0, 5'd16, 40'd24591));
    header_beats.push_back(make_beat(PlainLow, 64'd0, 5'd16, 40'hff_ffff_ffff));
    header_beats.push_back(make_beat('1, '1, 5'd31, '1));
    header_beats.push_back(make_beat(64'd0, 64'd0, 5'd0, 40'd0));
    header_beats.push_back(make_beat(64'h00b0_0102_1a53_454e, 64'd0, 5'd16, 40'd40976));
    header_beats.push_back(make_beat(64'h0832_0201_1a53_454e, 64'h0000_0000_0000_0020,
                                     5'd16, 40'd32784));
    header_beats.push_back(make_beat(V2Low, 64'h0200_0000_0700_0000, 5'd16, 40'd32784));
    header_beats.push_back(make_beat(64'h0840_0002_1a53_454e, 64'h0000_0000_0770_0000,
                                     5'd16, 40'd32784));
    repeat (RandomBeats) header_beats.push_back(random_header());

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (beat_idx < header_beats.size()) begin
      @(posedge clk_i);
      if (hdr_ch.valid && hdr_ch.ready) beat_idx++;
      phase <= beat_idx * 3 / header_beats.size();
      if (hdr_ch.valid && !hdr_ch.ready) begin
        // hold the pending beat
      end else if (beat_idx == header_beats.size()) begin
        hdr_ch.valid <= 1'b0;
      end else if ($urandom_range(0, 99) < (phase == 0 ? 32 : (phase == 1 ? 57 : 0))) begin
        hdr_ch.valid <= 1'b0;
      end else begin
        hdr_ch.valid <= 1'b1;
        hdr_ch.data <= header_beats[beat_idx];
      end
    end

    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && outstanding == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
